// ===== hw/rtl/mmr_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the megafly minimal route port unit.
// No dependencies.
package mmr_pkg;

  localparam int MAX_RADIX   = 64;
  localparam int ID_BITS     = 21;
  localparam int RADIX_W     = 7;
  localparam int PORT_W      = 6;
  localparam int P_W         = 6;
  localparam int CNT_W       = 23;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 7'd8;

  typedef enum logic [1:0] {
    NODE_SERVER,
    NODE_LEAF,
    NODE_SPINE,
    NODE_BAD
  } node_kind_t;

  typedef struct packed {
    logic [ID_BITS-1:0] current_node;
    logic [ID_BITS-1:0] dest_server;
  } hdr_t;

  typedef struct packed {
    logic [PORT_W-1:0] out_port;
    logic              invalid;
  } port_t;

  // one dividend lane: dividend shifts out at the top, quotient bits in at the bottom
  typedef struct packed {
    logic [ID_BITS-1:0] q;
    logic [P_W-1:0]     rem;
  } lane_t;

  typedef struct packed {
    logic [P_W-1:0]     p;
    node_kind_t         kind;
    logic [ID_BITS-1:0] cur_sw;
    logic [ID_BITS-1:0] cur_grp;
    logic [ID_BITS-1:0] dst_sw;
    logic [ID_BITS-1:0] dst_grp;
    logic [P_W-1:0]     dst_mod;
    logic [P_W-1:0]     dst_sw_mod;
  } side_t;

  typedef struct packed {
    side_t          side;
    lane_t [1:0]    lane;
  } cell_t;

endpackage

// ===== hw/rtl/mmr_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring division step on two lanes by the divisor p carried with the item.
// Depends on mmr_pkg.
module mmr_div_cell import mmr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  cell_t d,
  output logic  out_valid,
  input  logic  out_ready,
  output cell_t q
);

  cell_t          data_next;
  logic [P_W:0]   rem_sh [2];
  logic           ge [2];

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    data_next = d;
    for (int i = 0; i < 2; i++) begin
      rem_sh[i] = {d.lane[i].rem, d.lane[i].q[ID_BITS-1]};
      ge[i]     = rem_sh[i] >= {1'b0, d.side.p};
      data_next.lane[i].q   = {d.lane[i].q[ID_BITS-2:0], ge[i]};
      data_next.lane[i].rem = ge[i] ? P_W'(rem_sh[i] - {1'b0, d.side.p})
                                    : P_W'(rem_sh[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q <= data_next;
    end
  end

endmodule

// ===== hw/rtl/mmr_prep.sv =====
`timescale 1ns / 1ps
// Front stages: derive the network sizes from the radix and classify the node.
// Depends on mmr_pkg.
module mmr_prep import mmr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [RADIX_W-1:0] radix,
  input  logic               in_valid,
  output logic               in_ready,
  input  hdr_t               hdr,
  output logic               out_valid,
  input  logic               out_ready,
  output cell_t              q
);

  logic [4:0] v;
  logic [4:0] rdy;

  logic [ID_BITS-1:0] cur [4];
  logic [ID_BITS-1:0] dst [4];
  logic [RADIX_W-1:0] r1, r2;
  logic [P_W-1:0]     p [4];
  logic [10:0]        grps;
  logic [16:0]        sw3, sw4;
  logic [15:0]        leaves3, leaves4;
  logic [CNT_W-1:0]   servers;

  logic [RADIX_W-1:0] r_eff;
  logic [CNT_W-1:0]   d1, d2;
  cell_t              cls_next;

  assign rdy[4]    = !v[4] || out_ready;
  assign rdy[3:0]  = ~v[3:0] | rdy[4:1];
  assign in_ready  = rdy[0];
  assign out_valid = v[4];

  always_comb begin
    if (radix < RADIX_W'(2)) begin
      r_eff = RADIX_W'(2);
    end else if (radix > RADIX_W'(MAX_RADIX)) begin
      r_eff = RADIX_W'(MAX_RADIX);
    end else begin
      r_eff = radix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 4; i > 0; i--) begin
        if (rdy[i]) v[i] <= v[i-1];
      end
      if (rdy[0]) v[0] <= in_valid;
    end
  end

  // classify the item held in stage 3 against the sizes derived for it
  always_comb begin
    d1 = {2'b0, cur[3]} - servers;
    d2 = d1 - CNT_W'(leaves4);
    cls_next = '0;
    cls_next.side.p = p[3];
    cls_next.lane[0].q = dst[3];
    if ({2'b0, cur[3]} < servers) begin
      cls_next.side.kind = NODE_SERVER;
    end else if (d1 < CNT_W'(leaves4)) begin
      cls_next.side.kind = NODE_LEAF;
      cls_next.lane[1].q = d1[ID_BITS-1:0];
    end else if (d1 < CNT_W'(sw4)) begin
      cls_next.side.kind = NODE_SPINE;
      cls_next.lane[1].q = d2[ID_BITS-1:0];
    end else begin
      cls_next.side.kind = NODE_BAD;
    end
    cls_next.side.cur_sw = cls_next.lane[1].q;
  end

  always_ff @(posedge clk) begin
    if (rdy[0] && in_valid) begin
      cur[0] <= hdr.current_node;
      dst[0] <= hdr.dest_server;
      r1     <= r_eff;
      p[0]   <= P_W'(r_eff >> 1);
    end
    if (rdy[1] && v[0]) begin
      cur[1] <= cur[0];
      dst[1] <= dst[0];
      r2     <= r1;
      p[1]   <= p[0];
      grps   <= 11'(p[0]) * 11'(p[0]) + 11'd1;
    end
    if (rdy[2] && v[1]) begin
      cur[2]  <= cur[1];
      dst[2]  <= dst[1];
      p[2]    <= p[1];
      sw3     <= 17'(r2) * 17'(grps);
      leaves3 <= 16'((17'(r2) * 17'(grps)) >> 1);
    end
    if (rdy[3] && v[2]) begin
      cur[3]  <= cur[2];
      dst[3]  <= dst[2];
      p[3]    <= p[2];
      sw4     <= sw3;
      leaves4 <= leaves3;
      servers <= CNT_W'(p[2]) * CNT_W'(leaves3);
    end
    if (rdy[4] && v[3]) begin
      q      <= cls_next;
    end
  end

endmodule

// ===== hw/rtl/megafly_minimal_route_port_unit.sv =====
`timescale 1ns / 1ps
// Top level of the megafly minimal route port unit: front stages, three division
// chains of cells and the output register. Depends on mmr_pkg, mmr_prep, mmr_div_cell.
//
//  channel | signals                        | direction
//  hdr     | hdr_valid, hdr_stall, hdr      | in
//  port    | port_valid, port_stall, port   | out
//  cfg     | cfg_valid, cfg_ready, cfg_data | in (radix)
//
// One header per cycle unless port_stall holds the pipeline; a header passes the front stages and
// the three chains of one-bit division cells (dst/p, then /p again, then the global port).
// Each stage moves when the next one is empty or moving, so bubbles close up.
// Reset clears all valid bits and sets radix to 8.
module megafly_minimal_route_port_unit import mmr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               hdr_valid,
  output logic               hdr_stall,
  input  hdr_t               hdr,
  output logic               port_valid,
  input  logic               port_stall,
  output port_t              port,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RADIX_W-1:0] cfg_data
);

  logic [RADIX_W-1:0] radix;
  logic               hdr_ready;

  cell_t c1 [ID_BITS+1];
  cell_t c2 [ID_BITS+1];
  cell_t c3 [ID_BITS+1];
  logic [ID_BITS:0] v1, v2, v3, r1, r2, r3;

  logic              out_ready;
  port_t             port_next;
  side_t             s;

  assign cfg_ready = 1'b1;
  assign hdr_stall = !hdr_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      radix <= cfg_data;
    end
  end

  mmr_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .radix     (radix),
    .in_valid  (hdr_valid),
    .in_ready  (hdr_ready),
    .hdr       (hdr),
    .out_valid (v1[0]),
    .out_ready (r1[0]),
    .q         (c1[0])
  );

  // pass 1: dst/p and cur_sw/p
  // pass 2: dst_sw/p
  // pass 3: (dst_grp-1)/p and dst_grp/p
  always_comb begin
    c2[0] = c1[ID_BITS];
    c2[0].side.dst_sw  = c1[ID_BITS].lane[0].q;
    c2[0].side.dst_mod = c1[ID_BITS].lane[0].rem;
    c2[0].side.cur_grp = c1[ID_BITS].lane[1].q;
    c2[0].lane[0].rem  = '0;
    c2[0].lane[1]      = '0;

    c3[0] = c2[ID_BITS];
    c3[0].side.dst_grp    = c2[ID_BITS].lane[0].q;
    c3[0].side.dst_sw_mod = c2[ID_BITS].lane[0].rem;
    c3[0].lane[0].q       = c2[ID_BITS].lane[0].q - ID_BITS'(1);
    c3[0].lane[0].rem     = '0;
    c3[0].lane[1].q       = c2[ID_BITS].lane[0].q;
    c3[0].lane[1].rem     = '0;
  end

  assign v2[0] = v1[ID_BITS];
  assign r1[ID_BITS] = r2[0];
  assign v3[0] = v2[ID_BITS];
  assign r2[ID_BITS] = r3[0];
  assign r3[ID_BITS] = out_ready;

  for (genvar i = 0; i < ID_BITS; i++) begin : g_cells
    mmr_div_cell u_c1 (
      .clk(clk), .rst(rst),
      .in_valid(v1[i]), .in_ready(r1[i]), .d(c1[i]),
      .out_valid(v1[i+1]), .out_ready(r1[i+1]), .q(c1[i+1])
    );
    mmr_div_cell u_c2 (
      .clk(clk), .rst(rst),
      .in_valid(v2[i]), .in_ready(r2[i]), .d(c2[i]),
      .out_valid(v2[i+1]), .out_ready(r2[i+1]), .q(c2[i+1])
    );
    mmr_div_cell u_c3 (
      .clk(clk), .rst(rst),
      .in_valid(v3[i]), .in_ready(r3[i]), .d(c3[i]),
      .out_valid(v3[i+1]), .out_ready(r3[i+1]), .q(c3[i+1])
    );
  end

  always_comb begin
    s = c3[ID_BITS].side;
    port_next = '0;
    case (s.kind)
      NODE_LEAF: begin
        if (s.cur_sw == s.dst_sw) begin
          port_next.out_port = s.dst_mod;
        end else if (s.cur_grp == s.dst_grp) begin
          port_next.out_port = s.p + s.dst_sw_mod;
        end else if (s.cur_grp < s.dst_grp) begin
          port_next.out_port = s.p + c3[ID_BITS].lane[0].q[PORT_W-1:0];
        end else begin
          port_next.out_port = s.p + c3[ID_BITS].lane[1].q[PORT_W-1:0];
        end
      end
      NODE_SPINE: begin
        if (s.cur_grp == s.dst_grp) begin
          port_next.out_port = s.dst_sw_mod;
        end else if (s.cur_grp < s.dst_grp) begin
          port_next.out_port = s.p + c3[ID_BITS].lane[0].rem;
        end else begin
          port_next.out_port = s.p + c3[ID_BITS].lane[1].rem;
        end
      end
      NODE_BAD: port_next.invalid = 1'b1;
      default:  port_next = '0;
    endcase
  end

  assign out_ready = !port_valid || !port_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      port_valid <= 1'b0;
    end else if (out_ready) begin
      port_valid <= v3[ID_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && v3[ID_BITS]) begin
      port <= port_next;
    end
  end

endmodule

// ===== hw/rtl/mmr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the megafly minimal route port unit, bound to the top.
// Depends on mmr_pkg.
module mmr_checker import mmr_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  hdr_valid,
  input logic  hdr_stall,
  input logic  port_valid,
  input logic  port_stall,
  input port_t port
);

  // hold a stalled result
  a_port_hold: assert property (@(posedge clk) disable iff (rst)
    port_valid && port_stall |=> port_valid && $stable(port))
    else $error("stalled result changed");

  // a stalled header stays offered
  a_hdr_hold: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_stall |=> hdr_valid)
    else $error("stalled header withdrawn");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    port_valid && port.invalid |-> port.out_port == '0)
    else $error("invalid result with nonzero port");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !port_valid)
    else $error("result after reset");

  // no result is valid when reset has just fallen
  a_no_early: assert property (@(posedge clk)
    $fell(rst) |-> !port_valid)
    else $error("result too soon after reset");

endmodule

bind megafly_minimal_route_port_unit mmr_checker u_mmr_checker (
  .clk        (clk),
  .rst        (rst),
  .hdr_valid  (hdr_valid),
  .hdr_stall  (hdr_stall),
  .port_valid (port_valid),
  .port_stall (port_stall),
  .port       (port)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for megafly_minimal_route_port_unit: random and directed route
// headers, a scoreboard class that predicts the port. Depends on mmr_pkg.
module tb_top;
  import mmr_pkg::*;

  class route_board;
    logic [RADIX_W-1:0] radix_q;
    port_t want_q[$];
    int mismatches;

    function new();
      radix_q = RADIX_RESET;
      mismatches = 0;
    endfunction

    function port_t route_port(hdr_t h);
      longint unsigned r, p, grps, sw, leaves, servers, cur, dst, dsw, dgrp, csw, cgrp, pt;
      port_t res;
      r = radix_q;
      if (r < 2) r = 2;
      if (r > MAX_RADIX) r = MAX_RADIX;
      p = r / 2;
      grps = p * p + 1;
      sw = r * grps;
      leaves = sw / 2;
      servers = p * leaves;
      cur = h.current_node;
      dst = h.dest_server;
      dsw = dst / p;
      dgrp = dsw / p;
      pt = 0;
      res.invalid = 1'b0;
      if (cur < servers) begin
        pt = 0;
      end else if (cur - servers < leaves) begin
        csw = cur - servers;
        cgrp = csw / p;
        if (csw == dsw) pt = dst % p;
        else if (cgrp == dgrp) pt = p + dsw % p;
        else if (cgrp < dgrp) pt = p + (dgrp - 1) / p;
        else pt = p + dgrp / p;
      end else if (cur - servers < sw) begin
        csw = cur - servers - leaves;
        cgrp = csw / p;
        if (cgrp == dgrp) pt = dsw % p;
        else if (cgrp < dgrp) pt = p + (dgrp - 1) % p;
        else pt = p + dgrp % p;
      end else begin
        res.invalid = 1'b1;
      end
      res.out_port = pt[PORT_W-1:0];
      return res;
    endfunction

    function void note_header(hdr_t h);
      want_q.push_back(route_port(h));
    endfunction

    function void check_port(port_t got);
      port_t w;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected port transfer %h", got);
        return;
      end
      w = want_q.pop_front();
      if (got.out_port !== w.out_port || got.invalid !== w.invalid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("port mismatch: want port %0d inv %0d, got port %0d inv %0d",
                   w.out_port, w.invalid, got.out_port, got.invalid);
      end
    endfunction
  endclass

  logic clk, rst;
  logic hdr_valid, hdr_stall, port_valid, port_stall, cfg_valid, cfg_ready;
  hdr_t hdr;
  port_t port;
  logic [RADIX_W-1:0] cfg_data;
  route_board board;
  bit hold_off;
  int idle_cycles;

  megafly_minimal_route_port_unit dut (
    .clk(clk), .rst(rst), .hdr_valid(hdr_valid), .hdr_stall(hdr_stall), .hdr(hdr),
    .port_valid(port_valid), .port_stall(port_stall), .port(port),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // check ports, and count idle cycles since the last transfer
  always @(posedge clk) begin
    if (!rst && port_valid && !port_stall) board.check_port(port);
    if (!rst && ((hdr_valid && !hdr_stall) || (port_valid && !port_stall)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (idle_cycles > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int n;
    port_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_off) begin
        port_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
      end
      n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        port_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      port_stall <= 1'b0;
      do @(negedge clk); while (!(port_valid && !port_stall) && !hold_off);
    end
  end

  task automatic send_header(hdr_t h, bit gaps);
    int n;
    n = gaps ? $urandom_range(0, 15) : 0;
    if (n > 0) begin
      hdr_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    hdr <= h;
    hdr_valid <= 1'b1;
    @(posedge clk);
    while (hdr_stall) @(posedge clk);
    board.note_header(h);
    @(negedge clk);
  endtask

  task automatic drain();
    hdr_valid <= 1'b0;
    while (board.want_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_radix(logic [RADIX_W-1:0] r);
    cfg_data <= r;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.radix_q = r;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic hdr_t pick_header(logic [RADIX_W-1:0] r);
    hdr_t h;
    int unsigned rr, p, sw, servers, lim;
    rr = (r < 2) ? 2 : (r > MAX_RADIX) ? MAX_RADIX : r;
    p = rr / 2;
    sw = rr * (p * p + 1);
    servers = p * (sw / 2);
    lim = servers + sw;
    if (lim > 2097151) lim = 2097151;
    case ($urandom_range(0, 9))
      0: h.current_node = ID_BITS'($urandom_range(0, 2097151));
      1: h.current_node = ID_BITS'($urandom_range(0, servers));
      default: h.current_node = ID_BITS'($urandom_range(servers, lim));
    endcase
    h.dest_server = ($urandom_range(0, 9) == 0) ? ID_BITS'($urandom_range(0, 2097151))
                                                  : ID_BITS'($urandom_range(0, servers - 1));
    return h;
  endfunction

  initial begin
    logic [RADIX_W-1:0] radices[10];
    hdr_t h;
    board = new();
    hold_off = 1'b0;
    idle_cycles = 0;
    rst = 1'b1;
    hdr_valid = 1'b0;
    hdr = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    // directed: reset radix 8 (p=4, 17 groups, 136 switches, 272 servers)
    h.current_node = 0;        h.dest_server = 0;        send_header(h, 0);
    h.current_node = 1087;     h.dest_server = 5;        send_header(h, 0);
    h.current_node = 1088;     h.dest_server = 2;        send_header(h, 0);
    h.current_node = 1088;     h.dest_server = 9;        send_header(h, 0);
    h.current_node = 1088;     h.dest_server = 100;      send_header(h, 0);
    h.current_node = 1300;     h.dest_server = 3;        send_header(h, 0);
    h.current_node = 1360;     h.dest_server = 1;        send_header(h, 0);
    h.current_node = 1360;     h.dest_server = 500;      send_header(h, 0);
    h.current_node = 1631;     h.dest_server = 7;        send_header(h, 0);
    h.current_node = 1632;     h.dest_server = 0;        send_header(h, 0);
    h.current_node = 2097151;  h.dest_server = 2097151;  send_header(h, 0);
    h.current_node = 1200;     h.dest_server = 2097151;  send_header(h, 0);
    h.current_node = 1500;     h.dest_server = 2097151;  send_header(h, 0);
    h.current_node = 280;      h.dest_server = 3;        send_header(h, 0);
    h.current_node = 300;      h.dest_server = 200;      send_header(h, 0);
    h.current_node = 350;      h.dest_server = 10;       send_header(h, 0);
    h.current_node = 400;      h.dest_server = 5;        send_header(h, 0);
    drain();
    radices = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd127, 7'd64, 7'd65, 7'd5, 7'd17, 7'd8};
    foreach (radices[i]) begin
      write_radix(radices[i]);
      h.current_node = 0; h.dest_server = 2097151; send_header(h, 0);
      h.current_node = 2097151; h.dest_server = 0; send_header(h, 0);
      for (int k = 0; k < 100; k++) begin
        if (i == 3 && k == 10) hold_off = 1'b1;
        send_header(pick_header(radices[i]), k % 40 >= 20);
      end
      drain();
    end
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/mmr_pkg.sv
hw/rtl/mmr_div_cell.sv
hw/rtl/mmr_prep.sv
hw/rtl/megafly_minimal_route_port_unit.sv
hw/rtl/mmr_checker.sv
sim/tb_top.sv
